@@ sv/ostt_pkg.sv @@
// Shared types and constants for the ordered software timer table.
`timescale 1ns / 1ps
`default_nettype none

package ostt_pkg;

   // Default table geometry
   localparam int NUM_TIMERS_DEF    = 16;
   localparam int INTERVAL_BITS_DEF = 24;

   // Fixed field widths of the request and response
   localparam int ACTION_W   = 2;
   localparam int ID_W       = 4;
   localparam int TICK_W     = 32;
   localparam int INTERVAL_W = 24;

   // Request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_EXEC  = 2'd3
   } action_type;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MEASURE,
      ST_REPLY
   } state_type;

   // Status of the table scanner
   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } scan_flag_type;

endpackage

`default_nettype wire

@@ sv/ostt_if.sv @@
// Request and response channel interfaces of the ordered software timer table.
`timescale 1ns / 1ps
`default_nettype none

interface ostt_req_if
   import ostt_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [ID_W-1:0]       timer_id;
   logic [TICK_W-1:0]     time_value;
   logic                  absolute;
   logic                  repeat_req;
   logic [INTERVAL_W-1:0] interval;

   modport source (output valid, action, timer_id, time_value, absolute, repeat_req,
                   interval, input ready);
   modport sink (input valid, action, timer_id, time_value, absolute, repeat_req,
                 interval, output ready);
endinterface

interface ostt_rsp_if
   import ostt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              fired;
   logic [ID_W-1:0]   fired_id;
   logic [TICK_W-1:0] next_timeout;

   modport source (output valid, fired, fired_id, next_timeout, input ready);
   modport sink (input valid, fired, fired_id, next_timeout, output ready);
endinterface

`default_nettype wire

@@ sv/ordered_software_timer_table.sv @@
// Top level of the ordered software timer table: sequencer, timer flags and response register.
//
//   Channel  Dir  Handshake      Payload
//   req_if   in   valid/ready    action, timer_id, time_value, absolute, repeat_req, interval
//   rsp_if   out  valid/ready    fired, fired_id, next_timeout
//
// Each scan reads one memory entry per cycle.
// Tick, start and stop take one scan per request.
// Execute takes two scans (search, then timeout).
// Reset clears the tick counter and the running and repeating flags.
// A new request is taken while an earlier response still waits; a stalled
// response holds the sequencer in its reply state.
`timescale 1ns / 1ps
`default_nettype none

module ordered_software_timer_table
   import ostt_pkg::*;
#(
   parameter int NUM_TIMERS    = NUM_TIMERS_DEF,
   parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ostt_req_if.sink    req_if,
   ostt_rsp_if.source  rsp_if
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int PER_W = INTERVAL_BITS;

   state_type             state_ff, state_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [NUM_TIMERS-1:0] running_ff, running_in;
   logic [NUM_TIMERS-1:0] repeating_ff, repeating_in;
   action_type            act_ff, act_in;
   logic                  fired_ff, fired_in;
   logic [ID_W-1:0]       fired_id_ff, fired_id_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_fired_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [TICK_W-1:0]     rsp_nt_ff;
   logic                  rsp_load;

   action_type            req_act;
   logic                  id_ok;
   logic [IDX_W-1:0]      id_idx;

   logic                  scan_start;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [TICK_W-1:0]     wr_fire;
   logic [PER_W-1:0]      wr_per;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_idx;
   logic [TICK_W-1:0]     rd_fire;
   logic [PER_W-1:0]      rd_per;
   scan_flag_type         flags;
   logic [IDX_W-1:0]      best_idx;
   logic [TICK_W-1:0]     best_fire;
   logic [PER_W-1:0]      best_per;

   logic [TICK_W-1:0]     delta;
   logic                  due;
   logic [TICK_W-1:0]     next_timeout;

   ostt_mem #(
      .NUM_TIMERS (NUM_TIMERS),
      .PER_W      (PER_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_fire (wr_fire),
      .wr_per  (wr_per),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_fire (rd_fire),
      .rd_per  (rd_per)
   );

   ostt_scan #(
      .NUM_TIMERS (NUM_TIMERS),
      .PER_W      (PER_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .running   (running_ff),
      .rd_en     (rd_en),
      .rd_idx    (rd_idx),
      .rd_fire   (rd_fire),
      .rd_per    (rd_per),
      .flags     (flags),
      .best_idx  (best_idx),
      .best_fire (best_fire),
      .best_per  (best_per)
   );

   // Decode the request
   assign req_act = action_type'(req_if.action);
   assign id_ok   = (32'(req_if.timer_id) < NUM_TIMERS);
   assign id_idx  = IDX_W'(req_if.timer_id);

   // Time from now to the earliest timer; due when zero or past
   assign delta        = best_fire - tick_ff;
   assign due          = (delta == '0) || delta[TICK_W-1];
   assign next_timeout = !flags.found ? '1 : (due ? '0 : delta);

   assign req_if.ready = (state_ff == ST_IDLE);

   // Sequence the request: apply, search, fire, measure, reply
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      running_in   = running_ff;
      repeating_in = repeating_ff;
      act_in       = act_ff;
      fired_in     = fired_ff;
      fired_id_in  = fired_id_ff;
      scan_start   = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = best_idx;
      wr_fire      = best_fire + TICK_W'(best_per);
      wr_per       = best_per;
      rsp_vld_in   = rsp_vld_ff && !rsp_if.ready;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               act_in      = req_act;
               fired_in    = 1'b0;
               fired_id_in = '0;
               scan_start  = 1'b1;
               case (req_act)
                  ACT_TICK: begin
                     tick_in = tick_ff + TICK_W'(1);
                  end
                  ACT_START: begin
                     if (id_ok) begin
                        wr_en                = 1'b1;
                        wr_idx               = id_idx;
                        wr_fire              = req_if.absolute ? req_if.time_value
                                                               : req_if.time_value + tick_ff;
                        wr_per               = PER_W'(req_if.interval);
                        running_in[id_idx]   = 1'b1;
                        repeating_in[id_idx] = req_if.repeat_req;
                     end
                  end
                  ACT_STOP: begin
                     if (id_ok) begin
                        running_in[id_idx] = 1'b0;
                     end
                  end
                  default: ;
               endcase
               state_in = (req_act == ACT_EXEC) ? ST_SEARCH : ST_MEASURE;
            end
         end
         ST_SEARCH: begin
            if (flags.done) begin
               // Fire the earliest timer if due; re-arm or disarm it
               if (flags.found && due) begin
                  fired_in    = 1'b1;
                  fired_id_in = ID_W'(best_idx);
                  if (repeating_ff[best_idx]) begin
                     wr_en = 1'b1;
                  end else begin
                     running_in[best_idx] = 1'b0;
                  end
               end
               scan_start = 1'b1;
               state_in   = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            if (flags.done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_load   = 1'b1;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         running_ff   <= '0;
         repeating_ff <= '0;
         fired_ff     <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         running_ff   <= running_in;
         repeating_ff <= repeating_in;
         fired_ff     <= fired_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Hold the request action, fired index and the response payload
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      fired_id_ff <= fired_id_in;
      if (rsp_load) begin
         rsp_fired_ff <= fired_ff;
         rsp_id_ff    <= fired_id_ff;
         rsp_nt_ff    <= next_timeout;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.fired        = rsp_fired_ff;
   assign rsp_if.fired_id     = rsp_id_ff;
   assign rsp_if.next_timeout = rsp_nt_ff;

   a_fire_on_exec: assert property (@(posedge clock) disable iff (reset)
      fired_ff |-> (act_ff == ACT_EXEC))
      else $error("timer fired for a request other than execute");

   a_write_idle_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !flags.busy)
      else $error("entry written while the scanner reads the table");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      flags.done |-> (state_ff == ST_SEARCH) || (state_ff == ST_MEASURE))
      else $error("scan finished while the sequencer was not waiting on it");

   a_reply_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (state_ff == ST_IDLE) && rsp_vld_ff)
      else $error("response loaded but sequencer did not return to idle");

endmodule

`default_nettype wire

@@ sv/ostt_mem.sv @@
// Timer entry memory: fire tick and repeat period, one write and one read port.
`timescale 1ns / 1ps
`default_nettype none

module ostt_mem
   import ostt_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF,
   parameter int PER_W      = INTERVAL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] wr_idx,
   input  logic [TICK_W-1:0]     wr_fire,
   input  logic [PER_W-1:0]      wr_per,
   input  logic                  rd_en,
   input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] rd_idx,
   output logic [TICK_W-1:0]     rd_fire,
   output logic [PER_W-1:0]      rd_per
);

   logic [TICK_W-1:0] fire_mem [NUM_TIMERS];
   logic [PER_W-1:0]  per_mem [NUM_TIMERS];
   logic [TICK_W-1:0] rd_fire_ff;
   logic [PER_W-1:0]  rd_per_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fire_mem[wr_idx] <= wr_fire;
         per_mem[wr_idx]  <= wr_per;
      end
   end

   // Read the entry, data registered and available in the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_fire_ff <= fire_mem[rd_idx];
         rd_per_ff  <= per_mem[rd_idx];
      end
   end

   assign rd_fire = rd_fire_ff;
   assign rd_per  = rd_per_ff;

endmodule

`default_nettype wire

@@ sv/ostt_scan.sv @@
// Table scanner: walks the entry memory once and keeps the earliest running timer.
`timescale 1ns / 1ps
`default_nettype none

module ostt_scan
   import ostt_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEF,
   parameter int PER_W      = INTERVAL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_TIMERS-1:0] running,
   output logic                  rd_en,
   output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] rd_idx,
   input  logic [TICK_W-1:0]     rd_fire,
   input  logic [PER_W-1:0]      rd_per,
   output scan_flag_type         flags,
   output logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] best_idx,
   output logic [TICK_W-1:0]     best_fire,
   output logic [PER_W-1:0]      best_per
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              chk_ff, chk_last_ff;
   logic [IDX_W-1:0]  chk_idx_ff;
   logic              done_ff;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [TICK_W-1:0] best_fire_ff;
   logic [PER_W-1:0]  best_per_ff;
   logic              last_rd;
   logic [TICK_W-1:0] diff;
   logic              take;

   assign last_rd = (cnt_ff == CNT_W'(NUM_TIMERS - 1));
   assign rd_en   = busy_ff;
   assign rd_idx  = cnt_ff[IDX_W-1:0];

   // Advance the read address over all entries
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_rd) begin
            busy_in = 1'b0;
         end
      end
   end

   // Keep the entry only if it is strictly earlier, so ties stay at the lowest index
   assign diff     = rd_fire - best_fire_ff;
   assign take     = chk_ff && running[chk_idx_ff] && (!found_ff || diff[TICK_W-1]);
   assign found_in = start ? 1'b0 : (found_ff || take);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
         chk_ff      <= 1'b0;
         chk_last_ff <= 1'b0;
         done_ff     <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         chk_ff      <= busy_ff;
         chk_last_ff <= busy_ff && last_rd;
         done_ff     <= chk_ff && chk_last_ff;
         found_ff    <= found_in;
      end
   end

   // Hold the best entry
   always_ff @(posedge clock) begin
      chk_idx_ff <= rd_idx;
      if (take) begin
         best_idx_ff  <= chk_idx_ff;
         best_fire_ff <= rd_fire;
         best_per_ff  <= rd_per;
      end
   end

   assign flags.busy  = busy_ff || chk_ff;
   assign flags.done  = done_ff;
   assign flags.found = found_ff;
   assign best_idx    = best_idx_ff;
   assign best_fire   = best_fire_ff;
   assign best_per    = best_per_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !(busy_ff || chk_ff))
      else $error("scan started while a scan is in flight");

   a_done_after_walk: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && !chk_ff)
      else $error("scan done while entries are still being read");

endmodule

`default_nettype wire
